// File: rtl/gbn_pkg.sv
// shared types and constants for the go-back-n sender window core
package gbn_pkg;

    localparam int SEQ_W = 4;
    localparam int PAY_W = 64;
    localparam int OP_W  = 2;
    localparam int ACT_W = 2;

    localparam int DEF_WINDOW    = 8;
    localparam int DEF_SEQ_SPACE = 16;

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [ACT_W-1:0] {
        ACT_TX    = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_DONE  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND_START,
        ST_SEND_TX,
        ST_ACK_WALK,
        ST_ACK_STOP,
        ST_ACK_OLD,
        ST_ACK_NEW,
        ST_TO_STOP,
        ST_TO_START,
        ST_TO_TX,
        ST_DONE
    } t_state;

endpackage

// File: rtl/go_back_n_sender_window_core.sv
// go-back-n sender window core: packet store, window pointers and event sequencer
//
// Usage: drive an item on the i_ ports with start high while busy is low; the
// item is taken on that clock edge and busy rises on the next cycle. The item
// then produces one result beat per cycle on the o_ ports, each marked by
// o_valid for one cycle; the final beat has o_last set and carries o_accepted.
// o_window_full is the window state after the item, the same on every beat.
// The first result beat appears in the cycle after the item is taken.
// Beats before the finish beat (none for a refused send or a dropped ack):
//   send gives start if the window was empty, then tx; an acknowledgement
//   gives a stop for each entry below the acked one, for it and the old base,
//   then start for the new base if any; timeout: stop, start, tx per outstanding packet.
// One result leaves per cycle; a timeout reads the payload store through its
// single read port, one entry per beat, with the registered read hidden
// behind the start-timer beat. busy falls in the cycle after the last beat.
// The receiver cannot stall: every beat is taken in the cycle it is shown.
// Reset (synchronous, active low) empties the window and clears the full flag;
// the payload store keeps its contents and only written entries are ever read.
module go_back_n_sender_window_core
    import gbn_pkg::*;
#(
    parameter int WINDOW    = DEF_WINDOW,
    parameter int SEQ_SPACE = DEF_SEQ_SPACE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [PAY_W-1:0] i_payload,
    input  logic [SEQ_W-1:0] i_ack_number,
    input  logic             i_ack_checksum_ok,
    input  logic [SEQ_W-1:0] i_timer_sequence,
    output logic             o_valid,
    output logic [ACT_W-1:0] o_action,
    output logic [SEQ_W-1:0] o_sequence_res,
    output logic [PAY_W-1:0] o_packet_payload,
    output logic             o_accepted,
    output logic             o_window_full,
    output logic             o_last
);

    localparam int IDX_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int EFF_W = (WINDOW > SEQ_SPACE - 1) ? SEQ_SPACE - 1 :
                           ((WINDOW < 1) ? 1 : WINDOW);
    localparam logic [SEQ_W:0] EFF_WL   = EFF_W[SEQ_W:0];
    localparam logic [SEQ_W:0] SPACE_WL = SEQ_SPACE[SEQ_W:0];
    localparam logic [SEQ_W-1:0] LAST_SEQ = SEQ_W'(SEQ_SPACE - 1);

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s == LAST_SEQ) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SEQ_W-1:0] seq_diff(input logic [SEQ_W-1:0] a,
                                                  input logic [SEQ_W-1:0] b);
        logic [SEQ_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            t = t + SPACE_WL;
        end
        return t[SEQ_W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next, n_next;
    logic             r_full, n_full;
    logic [SEQ_W-1:0] r_ptr, n_ptr;
    logic [SEQ_W-1:0] r_tag, n_tag;
    logic             r_acc, n_acc;
    logic [PAY_W-1:0] r_pay;
    logic [PAY_W-1:0] r_rd_data;
    logic [SEQ_W-1:0] rd_addr;
    logic             accept;
    logic             ack_ok;
    logic [SEQ_W-1:0] outstanding;
    logic [SEQ_W:0]   out_plus;

    logic [PAY_W-1:0] mem [SEQ_SPACE];

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign outstanding = seq_diff(r_next, r_base);
    assign out_plus    = {1'b0, outstanding} + 1'b1;
    assign ack_ok      = i_ack_checksum_ok && ({1'b0, i_ack_number} < SPACE_WL) &&
                         (seq_diff(i_ack_number, r_base) < outstanding);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_base  <= '0;
            r_next  <= '0;
            r_full  <= 1'b0;
            r_ptr   <= '0;
            r_tag   <= '0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_next  <= n_next;
            r_full  <= n_full;
            r_ptr   <= n_ptr;
            r_tag   <= n_tag;
            r_acc   <= n_acc;
        end
    end

    // payload store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_SEND) && !r_full) begin
            mem[r_next[IDX_W-1:0]] <= i_payload;
        end
        r_rd_data <= mem[rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pay <= i_payload;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_base           = r_base;
        n_next           = r_next;
        n_full           = r_full;
        n_ptr            = r_ptr;
        n_tag            = r_tag;
        n_acc            = r_acc;
        rd_addr          = r_base;
        o_valid          = 1'b0;
        o_action         = ACT_DONE;
        o_sequence_res   = '0;
        o_packet_payload = '0;
        o_accepted       = 1'b0;
        o_last           = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_acc   = 1'b0;
                    n_state = ST_DONE;
                    case (i_opcode)
                        OP_SEND: begin
                            if (!r_full) begin
                                n_ptr   = r_next;
                                n_next  = seq_inc(r_next);
                                n_full  = (out_plus >= EFF_WL);
                                n_acc   = 1'b1;
                                n_state = (r_next == r_base) ? ST_SEND_START : ST_SEND_TX;
                            end
                        end
                        OP_ACK: begin
                            if (ack_ok) begin
                                n_tag   = i_ack_number;
                                n_ptr   = r_base;
                                n_full  = 1'b0;
                                n_acc   = 1'b1;
                                n_state = (i_ack_number == r_base) ? ST_ACK_STOP : ST_ACK_WALK;
                            end
                        end
                        OP_TIMEOUT: begin
                            n_tag   = i_timer_sequence;
                            n_state = ST_TO_STOP;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEND_START: begin
                o_valid        = 1'b1;
                o_action       = ACT_START;
                o_sequence_res = r_ptr;
                n_state        = ST_SEND_TX;
            end
            ST_SEND_TX: begin
                o_valid          = 1'b1;
                o_action         = ACT_TX;
                o_sequence_res   = r_ptr;
                o_packet_payload = r_pay;
                n_state          = ST_DONE;
            end
            ST_ACK_WALK: begin
                o_valid        = 1'b1;
                o_action       = ACT_STOP;
                o_sequence_res = r_ptr;
                n_ptr          = seq_inc(r_ptr);
                if (seq_inc(r_ptr) == r_tag) begin
                    n_state = ST_ACK_STOP;
                end
            end
            ST_ACK_STOP: begin
                o_valid        = 1'b1;
                o_action       = ACT_STOP;
                o_sequence_res = r_tag;
                n_state        = ST_ACK_OLD;
            end
            ST_ACK_OLD: begin
                o_valid        = 1'b1;
                o_action       = ACT_STOP;
                o_sequence_res = r_base;
                n_base         = seq_inc(r_tag);
                n_state        = (seq_inc(r_tag) != r_next) ? ST_ACK_NEW : ST_DONE;
            end
            ST_ACK_NEW: begin
                o_valid        = 1'b1;
                o_action       = ACT_START;
                o_sequence_res = r_base;
                n_state        = ST_DONE;
            end
            ST_TO_STOP: begin
                o_valid        = 1'b1;
                o_action       = ACT_STOP;
                o_sequence_res = r_tag;
                n_state        = ST_TO_START;
            end
            ST_TO_START: begin
                o_valid        = 1'b1;
                o_action       = ACT_START;
                o_sequence_res = r_tag;
                rd_addr        = r_base;
                n_ptr          = r_base;
                n_state        = (r_base != r_next) ? ST_TO_TX : ST_DONE;
            end
            ST_TO_TX: begin
                o_valid          = 1'b1;
                o_action         = ACT_TX;
                o_sequence_res   = r_ptr;
                o_packet_payload = r_rd_data;
                rd_addr          = seq_inc(r_ptr);
                n_ptr            = seq_inc(r_ptr);
                if (seq_inc(r_ptr) == r_next) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_valid    = 1'b1;
                o_action   = ACT_DONE;
                o_accepted = r_acc;
                o_last     = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_window_full = r_full;

    a_accept_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("no result beat after item taken");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && (o_action == ACT_DONE)))
        else $error("last beat is not the finish");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !busy)
        else $error("busy held after finish beat");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> ({1'b0, outstanding} == EFF_WL))
        else $error("full flag disagrees with outstanding count");

    a_accepted_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_accepted |-> o_last)
        else $error("accepted shown before finish");

endmodule

// File: verif/gbn_window_checker.sv
`timescale 1ns / 1ps
// checker for the go-back-n sender window core: predicts every result beat and compares it
module gbn_window_checker
    import gbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [PAY_W-1:0] i_payload,
    input  logic [SEQ_W-1:0] i_ack_number,
    input  logic             i_ack_checksum_ok,
    input  logic [SEQ_W-1:0] i_timer_sequence,
    input  logic             i_valid,
    input  logic [ACT_W-1:0] i_action,
    input  logic [SEQ_W-1:0] i_sequence_res,
    input  logic [PAY_W-1:0] i_packet_payload,
    input  logic             i_accepted,
    input  logic             i_window_full,
    input  logic             i_last,
    output int               o_errors,
    output int               o_pending
);

    localparam int SPAN  = DEF_SEQ_SPACE;
    localparam int LIMIT = (DEF_WINDOW > SPAN - 1) ? SPAN - 1 :
                           (DEF_WINDOW < 1) ? 1 : DEF_WINDOW;

    typedef struct {
        t_action          act;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] pay;
        logic             acc;
        logic             full;
        logic             last;
    } t_beat;

    t_beat            beat_q[$];
    logic [PAY_W-1:0] pay_store [SPAN];
    logic             ack_marks [SPAN];
    logic [SEQ_W-1:0] win_base;
    logic [SEQ_W-1:0] next_seq;
    logic             win_full;
    int               errors = 0;

    assign o_errors = errors;

    function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
        return SEQ_W'((int'(s) + 1) % SPAN);
    endfunction

    function automatic int in_flight();
        return (int'(next_seq) + SPAN - int'(win_base)) % SPAN;
    endfunction

    task automatic push_beat(input t_action a, input logic [SEQ_W-1:0] s,
                             input logic [PAY_W-1:0] p);
        t_beat b;
        b.act  = a;
        b.seq  = s;
        b.pay  = p;
        b.acc  = 1'b0;
        b.full = 1'b0;
        b.last = 1'b0;
        beat_q.push_back(b);
    endtask

    task automatic predict_item(input t_opcode op, input logic [PAY_W-1:0] pay,
                                input logic [SEQ_W-1:0] ack, input logic ck_ok,
                                input logic [SEQ_W-1:0] tseq);
        int               first;
        logic             took;
        logic [SEQ_W-1:0] idx;
        logic [SEQ_W-1:0] old_base;
        t_beat            fin;
        first = beat_q.size();
        took  = 1'b0;
        case (op)
            OP_SEND: begin
                if (!win_full) begin
                    idx      = next_seq;
                    next_seq = seq_next(next_seq);
                    if (idx == win_base) push_beat(ACT_START, idx, '0);
                    push_beat(ACT_TX, idx, pay);
                    pay_store[idx] = pay;
                    if (in_flight() >= LIMIT) win_full = 1'b1;
                    took = 1'b1;
                end
            end
            OP_ACK: begin
                if (ck_ok && ((int'(ack) + SPAN - int'(win_base)) % SPAN) < in_flight()) begin
                    old_base = win_base;
                    idx      = win_base;
                    while (idx != ack) begin
                        if (!ack_marks[idx]) begin
                            ack_marks[idx] = 1'b1;
                            push_beat(ACT_STOP, idx, '0);
                        end
                        idx = seq_next(idx);
                    end
                    push_beat(ACT_STOP, ack, '0);
                    ack_marks[ack] = 1'b1;
                    while (win_base != next_seq && ack_marks[win_base]) begin
                        ack_marks[win_base] = 1'b0;
                        win_base = seq_next(win_base);
                    end
                    if (old_base != win_base) begin
                        push_beat(ACT_STOP, old_base, '0);
                        if (win_base != next_seq) push_beat(ACT_START, win_base, '0);
                    end
                    if (in_flight() < LIMIT) win_full = 1'b0;
                    took = 1'b1;
                end
            end
            OP_TIMEOUT: begin
                push_beat(ACT_STOP, tseq, '0);
                push_beat(ACT_START, tseq, '0);
                idx = win_base;
                while (idx != next_seq) begin
                    push_beat(ACT_TX, idx, pay_store[idx]);
                    idx = seq_next(idx);
                end
            end
            default: begin
            end
        endcase
        push_beat(ACT_DONE, '0, '0);
        fin      = beat_q[beat_q.size() - 1];
        fin.acc  = took;
        fin.last = 1'b1;
        beat_q[beat_q.size() - 1] = fin;
        for (int k = first; k < beat_q.size(); k++) begin
            fin      = beat_q[k];
            fin.full = win_full;
            beat_q[k] = fin;
        end
    endtask

    always @(posedge i_clk) begin : check_beats
        t_beat want;
        if (!i_rst_n) begin
            for (int k = 0; k < SPAN; k++) ack_marks[k] = 1'b0;
            win_base = '0;
            next_seq = '0;
            win_full = 1'b0;
            beat_q.delete();
        end else begin
            if (i_start && !i_busy) begin
                predict_item(t_opcode'(i_opcode), i_payload, i_ack_number,
                             i_ack_checksum_ok, i_timer_sequence);
            end
            if (i_valid) begin
                if (beat_q.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected beat: act=%0d seq=%0d pay=%h acc=%b full=%b last=%b",
                                 i_action, i_sequence_res, i_packet_payload, i_accepted,
                                 i_window_full, i_last);
                    end
                    errors++;
                end else begin
                    want = beat_q.pop_front();
                    if (i_action !== want.act || i_sequence_res !== want.seq ||
                        i_packet_payload !== want.pay || i_accepted !== want.acc ||
                        i_window_full !== want.full || i_last !== want.last) begin
                        if (errors < 10) begin
                            $display("beat mismatch: expected act=%0d seq=%0d pay=%h acc=%b full=%b last=%b",
                                     want.act, want.seq, want.pay, want.acc, want.full, want.last);
                            $display("               got      act=%0d seq=%0d pay=%h acc=%b full=%b last=%b",
                                     i_action, i_sequence_res, i_packet_payload, i_accepted,
                                     i_window_full, i_last);
                        end
                        errors++;
                    end
                end
            end
        end
        o_pending <= beat_q.size();
    end

endmodule

// File: verif/tb_go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
// testbench top for the go-back-n sender window core: stimulus, pacing and verdict
module tb_go_back_n_sender_window_core;
    import gbn_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 82;

    logic             i_clk             = 1'b0;
    logic             i_rst_n           = 1'b0;
    logic             start             = 1'b0;
    logic             busy;
    logic [OP_W-1:0]  i_opcode          = OP_NONE;
    logic [PAY_W-1:0] i_payload         = '0;
    logic [SEQ_W-1:0] i_ack_number      = '0;
    logic             i_ack_checksum_ok = 1'b0;
    logic [SEQ_W-1:0] i_timer_sequence  = '0;
    logic             o_valid;
    logic [ACT_W-1:0] o_action;
    logic [SEQ_W-1:0] o_sequence_res;
    logic [PAY_W-1:0] o_packet_payload;
    logic             o_accepted;
    logic             o_window_full;
    logic             o_last;

    int               errors;
    int               pending;
    int               idle_pct = 0;
    int               quiet    = 0;
    logic [SEQ_W-1:0] win_lo   = '0;
    logic [SEQ_W-1:0] win_hi   = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    go_back_n_sender_window_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_payload         (i_payload),
        .i_ack_number      (i_ack_number),
        .i_ack_checksum_ok (i_ack_checksum_ok),
        .i_timer_sequence  (i_timer_sequence),
        .o_valid           (o_valid),
        .o_action          (o_action),
        .o_sequence_res    (o_sequence_res),
        .o_packet_payload  (o_packet_payload),
        .o_accepted        (o_accepted),
        .o_window_full     (o_window_full),
        .o_last            (o_last)
    );

    gbn_window_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_opcode          (i_opcode),
        .i_payload         (i_payload),
        .i_ack_number      (i_ack_number),
        .i_ack_checksum_ok (i_ack_checksum_ok),
        .i_timer_sequence  (i_timer_sequence),
        .i_valid           (o_valid),
        .i_action          (o_action),
        .i_sequence_res    (o_sequence_res),
        .i_packet_payload  (o_packet_payload),
        .i_accepted        (o_accepted),
        .i_window_full     (o_window_full),
        .i_last            (o_last),
        .o_errors          (errors),
        .o_pending         (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [PAY_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [SEQ_W-1:0] rand_seq();
        return SEQ_W'($urandom_range(DEF_SEQ_SPACE - 1));
    endfunction

    task automatic issue(input t_opcode op, input logic [PAY_W-1:0] pay,
                         input logic [SEQ_W-1:0] ack, input logic ck_ok,
                         input logic [SEQ_W-1:0] tseq);
        logic             taken;
        logic [SEQ_W-1:0] outs;
        logic [SEQ_W-1:0] dist_ack;
        i_opcode          <= op;
        i_payload         <= pay;
        i_ack_number      <= ack;
        i_ack_checksum_ok <= ck_ok;
        i_timer_sequence  <= tseq;
        taken = 1'b0;
        while (!taken) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
            taken = start && !busy;
        end
        // sender-side view of the window, only to steer acks into range
        outs     = win_hi - win_lo;
        dist_ack = ack - win_lo;
        if (op == OP_SEND && int'(outs) < DEF_WINDOW) begin
            win_hi = win_hi + 1'b1;
        end else if (op == OP_ACK && ck_ok && dist_ack < outs) begin
            win_lo = ack + 1'b1;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int               pick;
        int               outs;
        logic [SEQ_W-1:0] ack;
        outs = int'(SEQ_W'(win_hi - win_lo));
        pick = $urandom_range(99);
        if (pick < 45) begin
            issue(OP_SEND, rand_word(), rand_seq(), 1'($urandom), rand_seq());
        end else if (pick < 75 && outs != 0) begin
            ack = win_lo + SEQ_W'($urandom_range(outs - 1));
            issue(OP_ACK, rand_word(), ack, 1'b1, rand_seq());
        end else if (pick < 87) begin
            issue(OP_TIMEOUT, rand_word(), rand_seq(), 1'($urandom), rand_seq());
        end else begin
            case ($urandom_range(3))
                0: issue(OP_ACK, rand_word(), rand_seq(), 1'b0, rand_seq());
                1: begin
                    ack = win_lo + SEQ_W'(outs) + SEQ_W'($urandom_range(DEF_SEQ_SPACE - 1 - outs));
                    issue(OP_ACK, rand_word(), ack, 1'b1, rand_seq());
                end
                2: issue(OP_NONE, rand_word(), rand_seq(), 1'($urandom), rand_seq());
                default: issue(OP_SEND, rand_word(), rand_seq(), 1'($urandom), rand_seq());
            endcase
        end
    endtask

    initial begin
        int pct [3];
        pct[0] = 0;
        pct[1] = 77;
        pct[2] = 15;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty window: timeouts, ack with nothing outstanding, unused opcode
        issue(OP_TIMEOUT, '0, '0, 1'b0, 4'hf);
        issue(OP_TIMEOUT, '1, 4'hf, 1'b1, 4'h0);
        issue(OP_ACK, '0, 4'h5, 1'b1, '0);
        issue(OP_NONE, '1, 4'hf, 1'b1, 4'hf);
        // fill the window, then a refused send
        issue(OP_SEND, '0, '0, 1'b0, '0);
        issue(OP_SEND, '1, '1, 1'b1, '1);
        issue(OP_SEND, {16{4'h5}}, rand_seq(), 1'b0, rand_seq());
        issue(OP_SEND, {16{4'ha}}, rand_seq(), 1'b1, rand_seq());
        repeat (4) issue(OP_SEND, rand_word(), rand_seq(), 1'($urandom), rand_seq());
        issue(OP_SEND, rand_word(), '0, 1'b0, '0);
        // dropped acks: bad checksum, at next sequence, beyond it
        issue(OP_ACK, '0, 4'h3, 1'b0, '0);
        issue(OP_ACK, '0, 4'h8, 1'b1, '0);
        issue(OP_ACK, '0, 4'hf, 1'b1, '0);
        // partial ack, retransmit for another sequence, ack at the base
        issue(OP_ACK, '0, 4'h2, 1'b1, '0);
        issue(OP_TIMEOUT, '0, '0, 1'b0, 4'h9);
        issue(OP_ACK, '0, 4'h3, 1'b1, '0);
        repeat (4) issue(OP_SEND, rand_word(), rand_seq(), 1'($urandom), rand_seq());
        // ack of the newest packet empties the window
        issue(OP_ACK, '0, win_hi - 1'b1, 1'b1, '0);
        issue(OP_TIMEOUT, '0, '0, 1'b0, 4'h4);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = pct[ph];
            repeat (PHASE_ITEMS) random_item();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
